@@ hw/rtl/i2rt_pkg.sv @@
// Shared types, constants and helper functions for the integer-to-radix-text block.
// No dependencies; every other file refers to this package by scoped names.
package i2rt_pkg;

    // Input item field widths and positions inside the input tdata word.
    localparam int VALUE_BITS   = 64;
    localparam int MODE_POS     = 64;
    localparam int BASE_LSB     = 65;
    localparam int BASE_BITS    = 6;
    localparam int PAD_LSB      = 71;
    localparam int PAD_BITS     = 7;
    localparam int IN_DATA_BITS = 80;

    // Result item widths.
    localparam int CHAR_BITS     = 7;
    localparam int OUT_DATA_BITS = 8;

    // Digit store geometry and limits.
    localparam int MAX_CHARS  = 64;
    localparam int ADDR_BITS  = 6;
    localparam int COUNT_BITS = 7;

    localparam logic [BASE_BITS-1:0]  BASE_MIN  = 6'd2;
    localparam logic [BASE_BITS-1:0]  BASE_MAX  = 6'd36;
    localparam logic [PAD_BITS-1:0]   PAD_MAX   = 7'd64;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_A    = 7'h41;
    localparam logic [BASE_BITS-1:0]  TEN       = 6'd10;

    // Status of the shared divider, seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } i2rt_div_status_t;

    // Maps a digit value 0..35 to its ASCII character.
    function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [BASE_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        begin
            if (d < TEN)
            begin
                c = CHAR_ZERO + {1'b0, d};
            end
            else
            begin
                c = CHAR_A + {1'b0, d} - {1'b0, TEN};
            end
            return c;
        end
    endfunction

endpackage

@@ hw/rtl/i2rt_divider.sv @@
// Bit-serial restoring divider: divides a VALUE_WIDTH-bit quotient word by a 6-bit base.
// Depends on i2rt_pkg for the base width and the status struct.
module i2rt_divider #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [VALUE_WIDTH-1:0]             dividend,
    input  logic [i2rt_pkg::BASE_BITS-1:0]     divisor,
    output logic [VALUE_WIDTH-1:0]             quotient,
    output logic [i2rt_pkg::BASE_BITS-1:0]     remainder,
    output i2rt_pkg::i2rt_div_status_t         status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]           q_reg, q_next;
    logic [i2rt_pkg::BASE_BITS-1:0]   rem_reg, rem_next;
    logic [i2rt_pkg::BASE_BITS-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;

    logic [i2rt_pkg::BASE_BITS:0]     trial;
    logic [i2rt_pkg::BASE_BITS:0]     diff;
    logic                             ge;

    // One quotient bit per cycle: shift the next dividend bit into the remainder
    // and subtract the divisor when it fits.
    assign trial = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[i2rt_pkg::BASE_BITS-1:0] : trial[i2rt_pkg::BASE_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = q_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_W'(1) && !start) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

@@ hw/rtl/i2rt_digit_buf.sv @@
// Digit store: 64 entries of 6-bit digit values, one write port and one registered read port.
// Depends on i2rt_pkg for the depth and widths.
module i2rt_digit_buf (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [i2rt_pkg::ADDR_BITS-1:0]     wr_addr,
    input  logic [i2rt_pkg::BASE_BITS-1:0]     wr_data,
    input  logic [i2rt_pkg::ADDR_BITS-1:0]     rd_addr,
    output logic [i2rt_pkg::BASE_BITS-1:0]     rd_data
);

    logic [i2rt_pkg::BASE_BITS-1:0] mem [i2rt_pkg::MAX_CHARS];
    logic [i2rt_pkg::BASE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/integer_to_radix_text_top.sv @@
// The sequencer takes an item, then runs the shared bit-serial divider once per digit, then
// emits each character by a digit store read and an output load, which waits for a free output.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n, asynchronous, active low) clears the sequencer, counters and output valid;
// the digit store is not cleared, since every entry that is used is written before it is read.
module integer_to_radix_text_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input item stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata, from bit 0 up: value[63:0], mode, base[5:0], pad_width[6:0], zero fill.
    input  logic [i2rt_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // Result item stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, from bit 0 up: text_char[6:0], zero fill.
    output logic [i2rt_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // m_tuser, from bit 0 up: negative.
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    // The sequencer walks through: take item, run one division per digit, then read the
    // digits back most significant first and hand them to the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    localparam logic [i2rt_pkg::COUNT_BITS-1:0] LAST_SLOT =
        i2rt_pkg::COUNT_BITS'(i2rt_pkg::MAX_CHARS - 1);

    state_t                                state_reg, state_next;
    logic [VALUE_WIDTH-1:0]                quo_reg, quo_next;
    logic [i2rt_pkg::BASE_BITS-1:0]        base_reg, base_next;
    logic [i2rt_pkg::PAD_BITS-1:0]         pad_reg, pad_next;
    logic                                  neg_reg, neg_next;
    logic [i2rt_pkg::COUNT_BITS-1:0]       dcount_reg, dcount_next;
    logic [i2rt_pkg::COUNT_BITS-1:0]       pos_reg, pos_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [i2rt_pkg::CHAR_BITS-1:0]        out_char_reg, out_char_next;
    logic                                  out_neg_reg, out_neg_next;
    logic                                  out_last_reg, out_last_next;

    // Input field views.
    logic [VALUE_WIDTH-1:0]                in_value;
    logic                                  in_mode;
    logic [i2rt_pkg::BASE_BITS-1:0]        in_base;
    logic [i2rt_pkg::PAD_BITS-1:0]         in_pad;
    logic                                  in_neg;

    // Divider and digit store hookup.
    logic                                  div_start;
    logic [VALUE_WIDTH-1:0]                div_quotient;
    logic [i2rt_pkg::BASE_BITS-1:0]        div_remainder;
    i2rt_pkg::i2rt_div_status_t            div_status;
    logic                                  buf_wr_en;
    logic [i2rt_pkg::ADDR_BITS-1:0]        buf_rd_addr;
    logic [i2rt_pkg::BASE_BITS-1:0]        buf_rd_data;

    logic [i2rt_pkg::COUNT_BITS-1:0]       dcount_inc;
    logic [i2rt_pkg::COUNT_BITS-1:0]       total_chars;
    logic                                  out_free;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_mode  = s_tdata[i2rt_pkg::MODE_POS];
    assign in_base  = s_tdata[i2rt_pkg::BASE_LSB +: i2rt_pkg::BASE_BITS];
    assign in_pad   = s_tdata[i2rt_pkg::PAD_LSB +: i2rt_pkg::PAD_BITS];
    assign in_neg   = in_mode & in_value[VALUE_WIDTH-1];

    assign s_tready    = (state_reg == ST_IDLE);
    assign div_start   = (state_reg == ST_DIV_START);
    assign buf_wr_en   = (state_reg == ST_DIV_WAIT) && div_status.done;
    assign buf_rd_addr = pos_reg[i2rt_pkg::ADDR_BITS-1:0];
    assign out_free    = !out_valid_reg || m_tready;

    // Character count: the digits produced, or the pad width if that is larger.
    assign dcount_inc  = dcount_reg + 1'b1;
    assign total_chars = (pad_reg > dcount_inc) ? pad_reg : dcount_inc;

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        base_next      = base_reg;
        pad_next       = pad_reg;
        neg_next       = neg_reg;
        dcount_next    = dcount_reg;
        pos_next       = pos_reg;
        out_char_next  = out_char_reg;
        out_neg_next   = out_neg_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // The two's complement negation also gives the right magnitude
                    // for the most negative value.
                    quo_next    = in_neg ? (~in_value + 1'b1) : in_value;
                    neg_next    = in_neg;
                    base_next   = (in_base < i2rt_pkg::BASE_MIN) ? i2rt_pkg::BASE_MIN :
                                  (in_base > i2rt_pkg::BASE_MAX) ? i2rt_pkg::BASE_MAX : in_base;
                    pad_next    = (in_pad > i2rt_pkg::PAD_MAX) ? i2rt_pkg::PAD_MAX : in_pad;
                    dcount_next = '0;
                    state_next  = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    quo_next    = div_quotient;
                    dcount_next = dcount_inc;
                    if (div_quotient != '0 && dcount_reg != LAST_SLOT)
                    begin
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        pos_next   = total_chars - 1'b1;
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (out_free)
                begin
                    // Positions beyond the digit count are leading pad zeros.
                    out_char_next  = (pos_reg < dcount_reg) ?
                                     i2rt_pkg::digit_to_char(buf_rd_data) : i2rt_pkg::CHAR_ZERO;
                    out_neg_next   = neg_reg;
                    out_last_next  = (pos_reg == '0);
                    out_valid_next = 1'b1;
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - 1'b1;
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            base_reg      <= '0;
            pad_reg       <= '0;
            neg_reg       <= 1'b0;
            dcount_reg    <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_neg_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            base_reg      <= base_next;
            pad_reg       <= pad_next;
            neg_reg       <= neg_next;
            dcount_reg    <= dcount_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_neg_reg   <= out_neg_next;
            out_last_reg  <= out_last_next;
        end
    end

    i2rt_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (quo_reg),
        .divisor   (base_reg),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    i2rt_digit_buf u_digit_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (dcount_reg[i2rt_pkg::ADDR_BITS-1:0]),
        .wr_data (div_remainder),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_neg_reg;
    assign m_tlast  = out_last_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        dcount_reg <= i2rt_pkg::COUNT_BITS'(i2rt_pkg::MAX_CHARS))
        else $error("digit count beyond store depth");
    a_idle_divider_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_status.busy)
        else $error("divider busy while accepting an item");
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_LOAD) |-> (pos_reg < i2rt_pkg::COUNT_BITS'(i2rt_pkg::MAX_CHARS)))
        else $error("emit position beyond character limit");
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] >= 7'h30 && m_tdata[6:0] <= 7'h5A))
        else $error("result character out of range");

endmodule
